// ===== hw/rtl/tga_pkg.sv =====
`default_nettype none
package tga_pkg;

  // Result status codes
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_CLIP   = 2'd3;

  // Queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result item as it travels from the parser to the output stage.
  // px holds file bytes of the pixel, byte 0 in bits 7:0.
  typedef struct packed {
    logic [31:0] px;
    logic [7:0]  rep;
    logic        last;
    logic [1:0]  status;
    logic [1:0]  origin;   // bit 1 top, bit 0 right
    logic [15:0] width;
    logic [15:0] height;
  } ev_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tga_front.sv =====
`default_nettype none
module tga_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  byte_in,
  input  wire logic        file_start,
  output tga_pkg::ev_t     ev,
  output logic             ev_valid
);
  import tga_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [4:0] HP_TYPE  = 5'd2;
  localparam logic [4:0] HP_WLO   = 5'd12;
  localparam logic [4:0] HP_WHI   = 5'd13;
  localparam logic [4:0] HP_HLO   = 5'd14;
  localparam logic [4:0] HP_HHI   = 5'd15;
  localparam logic [4:0] HP_DEPTH = 5'd16;
  localparam logic [4:0] HP_DESC  = 5'd17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  logic [4:0]  header_pos, header_pos_next;
  logic [1:0]  phase, phase_next;
  logic        compressed_mode, compressed_mode_next;
  logic        four_byte_pixels, four_byte_pixels_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [31:0] pixel_accum, pixel_accum_next;
  logic [1:0]  origin_bits, origin_bits_next;

  logic [31:0] area;
  logic [31:0] accum_v;
  logic [31:0] pixels_after;
  logic [1:0]  need_last;
  logic [7:0]  rep;
  logic [1:0]  st;
  logic [31:0] ev_px;
  logic [7:0]  ev_rep;
  logic        ev_last;
  logic [1:0]  ev_st;

  assign area      = 32'(width_reg) * 32'(height_reg);
  assign need_last = four_byte_pixels ? 2'd3 : 2'd2;
  assign accum_v   = pixel_accum | ({24'b0, byte_in} << {byte_in_pixel, 3'b000});

  always_comb begin
    header_pos_next       = header_pos;
    phase_next            = phase;
    compressed_mode_next  = compressed_mode;
    four_byte_pixels_next = four_byte_pixels;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    pixels_left_next      = pixels_left;
    packet_is_run_next    = packet_is_run;
    packet_left_next      = packet_left;
    byte_in_pixel_next    = byte_in_pixel;
    pixel_accum_next      = pixel_accum;
    origin_bits_next      = origin_bits;
    ev_valid              = 1'b0;
    ev_px                 = '0;
    ev_rep                = '0;
    ev_last               = 1'b0;
    ev_st                 = ST_PIXEL;
    rep                   = 8'd1;
    st                    = ST_PIXEL;
    pixels_after          = pixels_left - 32'(rep);

    if (accept) begin
      if (file_start) begin
        header_pos_next       = 5'd1;
        phase_next            = PH_HEADER;
        compressed_mode_next  = 1'b0;
        four_byte_pixels_next = 1'b0;
        width_reg_next        = '0;
        height_reg_next       = '0;
        pixels_left_next      = '0;
        packet_is_run_next    = 1'b0;
        packet_left_next      = '0;
        byte_in_pixel_next    = '0;
        pixel_accum_next      = '0;
        origin_bits_next      = '0;
      end else if (phase == PH_HEADER) begin
        header_pos_next = header_pos + 5'd1;
        unique case (header_pos)
          HP_TYPE: begin
            if (byte_in != TYPE_RAW && byte_in != TYPE_RLE) begin
              phase_next = PH_IDLE;
              ev_valid   = 1'b1;
              ev_st      = ST_REJECT;
            end else begin
              compressed_mode_next = (byte_in == TYPE_RLE);
            end
          end
          HP_WLO: width_reg_next[7:0]   = byte_in;
          HP_WHI: width_reg_next[15:8]  = byte_in;
          HP_HLO: height_reg_next[7:0]  = byte_in;
          HP_HHI: height_reg_next[15:8] = byte_in;
          HP_DEPTH: begin
            if (byte_in != DEPTH_24 && byte_in != DEPTH_32) begin
              phase_next = PH_IDLE;
              ev_valid   = 1'b1;
              ev_st      = ST_REJECT;
            end else begin
              four_byte_pixels_next = (byte_in == DEPTH_32);
            end
          end
          HP_DESC: begin
            origin_bits_next   = byte_in[5:4];
            pixels_left_next   = area;
            packet_left_next   = '0;
            packet_is_run_next = 1'b0;
            byte_in_pixel_next = '0;
            pixel_accum_next   = '0;
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
              phase_next = PH_DONE;
              ev_valid   = 1'b1;
              ev_last    = 1'b1;
              ev_st      = ST_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
          default: ;
        endcase
      end else if (phase == PH_DATA) begin
        if (compressed_mode && packet_left == 8'd0) begin
          // packet header byte
          packet_is_run_next = byte_in[7];
          packet_left_next   = {1'b0, byte_in[6:0]} + 8'd1;
          byte_in_pixel_next = '0;
          pixel_accum_next   = '0;
        end else if (byte_in_pixel < need_last) begin
          pixel_accum_next   = accum_v;
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          byte_in_pixel_next = '0;
          if (compressed_mode && packet_is_run) begin
            rep = packet_left;
            if (32'(packet_left) > pixels_left) begin
              rep = pixels_left[7:0];
              st  = ST_CLIP;
            end
            packet_left_next = '0;
          end else if (compressed_mode) begin
            packet_left_next = packet_left - 8'd1;
            if (packet_left != 8'd1 && pixels_left == 32'd1) st = ST_CLIP;
          end
          pixels_after     = pixels_left - 32'(rep);
          pixels_left_next = pixels_after;
          if (pixels_after == 32'd0) phase_next = PH_DONE;
          ev_valid         = 1'b1;
          ev_px            = accum_v;
          ev_rep           = rep;
          ev_last          = (pixels_after == 32'd0);
          ev_st            = st;
          pixel_accum_next = '0;
        end
      end
    end
  end

  always_comb begin
    ev.px     = ev_px;
    ev.rep    = ev_rep;
    ev.last   = ev_last;
    ev.status = ev_st;
    ev.origin = origin_bits_next;
    ev.width  = width_reg_next;
    ev.height = height_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos       <= '0;
      phase            <= PH_IDLE;
      compressed_mode  <= 1'b0;
      four_byte_pixels <= 1'b0;
      width_reg        <= '0;
      height_reg       <= '0;
      pixels_left      <= '0;
      packet_is_run    <= 1'b0;
      packet_left      <= '0;
      byte_in_pixel    <= '0;
      pixel_accum      <= '0;
      origin_bits      <= '0;
    end else begin
      header_pos       <= header_pos_next;
      phase            <= phase_next;
      compressed_mode  <= compressed_mode_next;
      four_byte_pixels <= four_byte_pixels_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
      pixels_left      <= pixels_left_next;
      packet_is_run    <= packet_is_run_next;
      packet_left      <= packet_left_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixel_accum      <= pixel_accum_next;
      origin_bits      <= origin_bits_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tga_queue.sv =====
`default_nettype none
module tga_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire tga_pkg::ev_t wr_ev,
  output logic             full,
  output logic             rd_valid,
  output tga_pkg::ev_t     rd_ev,
  input  wire logic        rd_en
);
  import tga_pkg::*;

  ev_t            slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_wr;
  logic           do_rd;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_ev    = slots[rptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QAW'(1);
      if (do_rd) rptr <= rptr + QAW'(1);
      count <= count + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tga_back.sv =====
`default_nettype none
module tga_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire tga_pkg::ev_t q_ev,
  output logic             q_take,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic [7:0]       repeat_count,
  output logic             last_pixel,
  output logic [1:0]       status,
  output logic             top_origin,
  output logic             right_origin,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height
);
  import tga_pkg::*;

  ev_t  hold;
  logic hold_valid;

  assign q_take = q_valid && (!hold_valid || pop);
  assign empty  = !hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (q_take) begin
      hold_valid <= 1'b1;
    end else if (pop) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) hold <= q_ev;
  end

  // file order is blue, green, red, alpha
  assign blue         = hold.px[7:0];
  assign green        = hold.px[15:8];
  assign red          = hold.px[23:16];
  assign alpha        = hold.px[31:24];
  assign repeat_count = hold.rep;
  assign last_pixel   = hold.last;
  assign status       = hold.status;
  assign top_origin   = hold.origin[1];
  assign right_origin = hold.origin[0];
  assign image_width  = hold.width;
  assign image_height = hold.height;

endmodule
`default_nettype wire

// ===== hw/rtl/tga_rle_decoder.sv =====
// Path: an accepted byte's result is written into the result queue, then
// registered in the output register, where it can be popped.
// Throughput: one file byte per cycle unless full is high, set by tga_front;
// a four-entry result queue plus the output register absorb pop stalls.
// Reset: synchronous, active high; parser idles until a file_start item,
// the queue and the output register come up empty.
`default_nettype none
module tga_rle_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_in,
  input  wire logic        file_start,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic [7:0]       repeat_count,
  output logic             last_pixel,
  output logic [1:0]       status,
  output logic             top_origin,
  output logic             right_origin,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height
);
  import tga_pkg::*;

  ev_t  front_ev;
  logic front_valid;
  logic accept;
  ev_t  q_ev;
  logic q_valid;
  logic q_take;

  // Accept a byte whenever the queue has room. Each byte makes at most one
  // result, so a free slot is all the parser ever needs.
  assign accept = push && !full;

  // Front: parse the header, gather pixel bytes, expand packets into
  // pixel results with repeat counts, clip overruns.
  tga_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .file_start (file_start),
    .ev         (front_ev),
    .ev_valid   (front_valid)
  );

  // Queue: hold finished results so the parser keeps going while the
  // consumer stalls.
  tga_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_ev    (front_ev),
    .full     (full),
    .rd_valid (q_valid),
    .rd_ev    (q_ev),
    .rd_en    (q_take)
  );

  // Back: register the oldest result and split the pixel into components.
  tga_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ev         (q_ev),
    .q_take       (q_take),
    .pop          (pop),
    .empty        (empty),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel),
    .status       (status),
    .top_origin   (top_origin),
    .right_origin (right_origin),
    .image_width  (image_width),
    .image_height (image_height)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tga_pkg::*;

  // TGA header codes and byte positions
  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] DEPTH_16  = 8'd16;
  localparam int HDR_LEN       = 18;
  localparam int HDR_TYPE      = 2;
  localparam int HDR_WIDTH_LO  = 12;
  localparam int HDR_WIDTH_HI  = 13;
  localparam int HDR_HEIGHT_LO = 14;
  localparam int HDR_HEIGHT_HI = 15;
  localparam int HDR_DEPTH     = 16;
  localparam int HDR_DESC      = 17;
  localparam int LIVE_TARGET   = 480;

  typedef enum logic [1:0] {DEC_IDLE, DEC_HEADER, DEC_DATA, DEC_DONE} dec_phase_t;

  // One expected pixel or status item, as it must show on the result ports
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  rep;
    logic        last;
    logic [1:0]  status;
    logic        top;
    logic        right;
    logic [15:0] width;
    logic [15:0] height;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  byte_in;
  logic        file_start;
  logic        empty;
  logic        pop;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_count;
  logic        last_pixel;
  logic [1:0]  status;
  logic        top_origin;
  logic        right_origin;
  logic [15:0] image_width;
  logic [15:0] image_height;

  tga_rle_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .byte_in      (byte_in),
    .file_start   (file_start),
    .empty        (empty),
    .pop          (pop),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel),
    .status       (status),
    .top_origin   (top_origin),
    .right_origin (right_origin),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Decoder shadow state, kept in step with every accepted item
  dec_phase_t  dec_phase;
  logic [4:0]  hdr_pos;
  logic        rle_mode;
  logic        wide_px;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] px_owed;
  logic        run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_idx;
  logic [31:0] accum;
  logic [1:0]  origin;

  pixel_t pixel_q[$];
  int     errors     = 0;
  int     live_items = 0;
  bit     push_burst = 0;
  bit     pop_burst  = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Clear the shadow decoder, as reset and a file start do
  task automatic clear_decoder();
    dec_phase = DEC_IDLE;
    hdr_pos   = '0;
    rle_mode  = 1'b0;
    wide_px   = 1'b0;
    width_r   = '0;
    height_r  = '0;
    px_owed   = '0;
    run_pkt   = 1'b0;
    pkt_left  = '0;
    byte_idx  = '0;
    accum     = '0;
    origin    = '0;
  endtask

  // Queue one expected item; origin and size come from the current header state
  task automatic note_result(input logic [31:0] px, input logic [7:0] rep,
                             input logic last, input logic [1:0] st);
    pixel_t item;
    item.red    = px[23:16];
    item.green  = px[15:8];
    item.blue   = px[7:0];
    item.alpha  = px[31:24];
    item.rep    = rep;
    item.last   = last;
    item.status = st;
    item.top    = origin[1];
    item.right  = origin[0];
    item.width  = width_r;
    item.height = height_r;
    pixel_q.push_back(item);
  endtask

  // Advance the shadow decoder by one file byte and queue what it produces
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [4:0] pos;
    logic [1:0] need_last;
    logic [7:0] rep;
    logic [1:0] st;
    if (fs) begin
      clear_decoder();
      dec_phase = DEC_HEADER;
      hdr_pos   = 5'd1;
    end else if (dec_phase == DEC_HEADER) begin
      pos     = hdr_pos;
      hdr_pos = hdr_pos + 5'd1;
      case (int'(pos))
        HDR_TYPE: begin
          if (b != TYPE_RAW && b != TYPE_RLE) begin
            dec_phase = DEC_IDLE;
            note_result('0, '0, 1'b0, ST_REJECT);
          end else begin
            rle_mode = (b == TYPE_RLE);
          end
        end
        HDR_WIDTH_LO:  width_r[7:0]   = b;
        HDR_WIDTH_HI:  width_r[15:8]  = b;
        HDR_HEIGHT_LO: height_r[7:0]  = b;
        HDR_HEIGHT_HI: height_r[15:8] = b;
        HDR_DEPTH: begin
          if (b != DEPTH_24 && b != DEPTH_32) begin
            dec_phase = DEC_IDLE;
            note_result('0, '0, 1'b0, ST_REJECT);
          end else begin
            wide_px = (b == DEPTH_32);
          end
        end
        HDR_DESC: begin
          origin   = b[5:4];
          px_owed  = {16'd0, width_r} * {16'd0, height_r};
          pkt_left = '0;
          run_pkt  = 1'b0;
          byte_idx = '0;
          accum    = '0;
          if (px_owed == 0) begin
            dec_phase = DEC_DONE;
            note_result('0, '0, 1'b1, ST_EMPTY);
          end else begin
            dec_phase = DEC_DATA;
          end
        end
        default: ;
      endcase
    end else if (dec_phase == DEC_DATA) begin
      need_last = wide_px ? 2'd3 : 2'd2;
      if (rle_mode && pkt_left == 0) begin
        // packet header: flag bit picks run or raw, low bits hold count minus one
        run_pkt  = b[7];
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        byte_idx = '0;
        accum    = '0;
      end else begin
        accum = accum | ({24'd0, b} << (8 * byte_idx));
        if (byte_idx < need_last) begin
          byte_idx = byte_idx + 2'd1;
        end else begin
          byte_idx = '0;
          rep      = 8'd1;
          st       = ST_PIXEL;
          if (rle_mode && run_pkt) begin
            rep = pkt_left;
            if ({24'd0, rep} > px_owed) begin
              rep = px_owed[7:0];
              st  = ST_CLIP;
            end
            pkt_left = '0;
          end else if (rle_mode) begin
            pkt_left = pkt_left - 8'd1;
            if (pkt_left != 0 && px_owed == 1) st = ST_CLIP;
          end
          px_owed = px_owed - {24'd0, rep};
          if (px_owed == 0) dec_phase = DEC_DONE;
          note_result(accum, rep, px_owed == 0, st);
          accum = '0;
        end
      end
    end
  endtask

  // Send one item: idle a random gap, hold push until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    byte_in    <= b;
    file_start <= fs;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    if (fs || dec_phase == DEC_HEADER || dec_phase == DEC_DATA) live_items++;
    decode_byte(b, fs);
  endtask

  // Send an 18-byte header; skipped bytes carry random filler
  task automatic send_header(input logic [7:0] ftype, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth,
                             input logic [7:0] desc);
    int pos;
    for (pos = 0; pos < HDR_LEN; pos++) begin
      case (pos)
        HDR_TYPE:      send_byte(ftype, 1'b0);
        HDR_WIDTH_LO:  send_byte(w[7:0], 1'b0);
        HDR_WIDTH_HI:  send_byte(w[15:8], 1'b0);
        HDR_HEIGHT_LO: send_byte(h[7:0], 1'b0);
        HDR_HEIGHT_HI: send_byte(h[15:8], 1'b0);
        HDR_DEPTH:     send_byte(depth, 1'b0);
        HDR_DESC:      send_byte(desc, 1'b0);
        default:       send_byte(8'($urandom_range(0, 255)), pos == 0);
      endcase
    end
  endtask

  // Send one pixel in file order: blue, green, red, then alpha if present
  task automatic send_pixel(input logic [31:0] px, input int bpp);
    int i;
    for (i = 0; i < bpp; i++) send_byte(px[8*i +: 8], 1'b0);
  endtask

  task automatic test_ignored_bytes();
    // nothing has started yet, so drop these without a result
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_raw_24();
    send_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_24, 8'h20);
    send_pixel(32'h0000_0000, 3);
    send_pixel(32'h00FF_FFFF, 3);
    send_byte(8'h5A, 1'b0);  // image complete: ignored
  endtask

  task automatic test_rle_32();
    // run copies all four bytes, alpha included, then a one-pixel raw packet
    send_header(TYPE_RLE, 16'd3, 16'd1, DEPTH_32, 8'h10);
    send_byte(8'h81, 1'b0);
    send_pixel(32'h4433_2211, 4);
    send_byte(8'h00, 1'b0);
    send_pixel(32'hFFFF_FFFF, 4);
  endtask

  task automatic test_run_overrun();
    // 128-pixel run into a 4-pixel image: clip it
    send_header(TYPE_RLE, 16'd2, 16'd2, DEPTH_24, 8'hFF);
    send_byte(8'hFF, 1'b0);
    send_pixel(32'h00A5_C3E7, 3);
  endtask

  task automatic test_raw_overrun();
    // three-pixel raw packet into a one-pixel image: the rest is dropped
    send_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_32, 8'h00);
    send_byte(8'h02, 1'b0);
    repeat (3) send_pixel($urandom, 4);
  endtask

  task automatic test_bad_header();
    send_header(8'h03, 16'd1, 16'd1, DEPTH_24, 8'h00);
    send_header(8'hFF, 16'd1, 16'd1, DEPTH_32, 8'h30);
    send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_16, 8'h00);
  endtask

  task automatic test_empty_image();
    send_header(TYPE_RAW, 16'hFFFF, 16'h0000, DEPTH_32, 8'h30);
    send_header(TYPE_RLE, 16'h0000, 16'hFFFF, DEPTH_24, 8'h00);
  endtask

  task automatic test_restart();
    // abandon a header partway, then a clean one-pixel file
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(TYPE_RLE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24, 8'h00);
    send_pixel($urandom, 3);
  endtask

  // One random file: mostly well formed, some broken, huge or truncated
  task automatic send_random_file();
    int kind, bpp, owed, n, limit;
    logic [7:0]  ftype, depth, cnt;
    logic [15:0] w, h;
    kind  = $urandom_range(0, 99);
    ftype = $urandom_range(0, 3) != 0 ? TYPE_RLE : TYPE_RAW;
    depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    w     = 16'($urandom_range(1, 5));
    h     = 16'($urandom_range(1, 4));
    if (kind < 8) begin
      ftype = 8'($urandom_range(0, 255));
    end else if (kind < 14) begin
      depth = 8'($urandom_range(0, 255));
    end else if (kind < 19) begin
      if ($urandom_range(0, 1)) begin
        w = '0;
        h = 16'($urandom);
      end else begin
        w = 16'($urandom);
        h = '0;
      end
    end else if (kind < 26) begin
      w = 16'($urandom);
      h = 16'($urandom);
    end else if (kind < 34) begin
      w = 16'($urandom_range(8, 24));
      h = 16'($urandom_range(6, 10));
    end
    push_burst = ($urandom_range(0, 4) == 0);
    send_header(ftype, w, h, depth, 8'($urandom_range(0, 255)));
    bpp = (depth == DEPTH_32) ? 4 : 3;
    if (kind < 19) owed = $urandom_range(0, 3);
    else if (kind < 26) owed = $urandom_range(10, 40);
    else owed = w * h;
    while (owed > 0) begin
      if (ftype == TYPE_RLE) begin
        limit = (owed < 8) ? owed : 8;
        n     = $urandom_range(1, limit);
        if ($urandom_range(0, 9) == 0) n = owed + $urandom_range(1, 3);
        if (n > 128) n = 128;
        cnt = 8'(n - 1);
        if ($urandom_range(0, 1)) begin
          // run packet; sometimes the longest one or one that fills the rest
          if ($urandom_range(0, 15) == 0) cnt = 8'h7F;
          else if ($urandom_range(0, 7) == 0 && owed <= 128) cnt = 8'(owed - 1);
          send_byte({1'b1, cnt[6:0]}, 1'b0);
          send_pixel($urandom, bpp);
          n = int'(cnt) + 1;
        end else begin
          send_byte({1'b0, cnt[6:0]}, 1'b0);
          repeat (n) send_pixel($urandom, bpp);
        end
        owed -= n;
      end else begin
        send_pixel($urandom, bpp);
        owed--;
      end
      if ($urandom_range(0, 199) == 0) break;  // truncate; next file start cuts in
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_random_files();
    while (live_items < LIVE_TARGET) send_random_file();
  endtask

  // Compare one field, report every mismatch
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: pop with random gaps, check each item against the oldest expectation
  initial begin : result_check
    pixel_t want;
    int     gap;
    pop = 1'b0;
    forever begin
      gap = pop_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (rst !== 1'b0 || empty !== 1'b0) @(posedge clk);
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual status %0h rep %0h", $time,
                 status, repeat_count);
      end else begin
        want = pixel_q.pop_front();
        check_field("red", want.red, red);
        check_field("green", want.green, green);
        check_field("blue", want.blue, blue);
        check_field("alpha", want.alpha, alpha);
        check_field("repeat_count", want.rep, repeat_count);
        check_field("last_pixel", want.last, last_pixel);
        check_field("status", want.status, status);
        check_field("top_origin", want.top, top_origin);
        check_field("right_origin", want.right, right_origin);
        check_field("image_width", want.width, image_width);
        check_field("image_height", want.height, image_height);
      end
      if ($urandom_range(0, 31) == 0) pop_burst = !pop_burst;
    end
  end

  // Stimulus: reset once, directed files, then random files, then drain
  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    byte_in    = '0;
    file_start = 1'b0;
    clear_decoder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_ignored_bytes();
    test_raw_24();
    test_rle_32();
    test_run_overrun();
    test_raw_overrun();
    test_bad_header();
    test_empty_image();
    test_restart();
    test_random_files();

    // drain: wait for every expectation, then linger for stray results
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
